// ===== rtl/aept_pkg.sv =====
package aept_pkg;

   // Field widths of the stream payloads
   localparam int OPCODE_W      = 2;
   localparam int ANGLE_FIELD_W = 14;
   localparam int INDEX_FIELD_W = 10;
   localparam int PHASE_W       = 12;
   localparam int COUNT_W       = 32;
   localparam int PPR_W         = 21;

   // Packed bus widths
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_FIELDS_W = 1 + 2 * ANGLE_FIELD_W + PHASE_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = PPR_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_CORRECTION_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_PER_REV     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_PHASE_OFFSET = 2'd2;

   localparam logic [PPR_W-1:0] PPR_RESET = 21'd204800;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_READING      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TABLE_WRITE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_TURNS  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_SET_POLARITY = 2'd3;

   // Control of one item in the front stages
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                failed;
      logic                want_reversed;
   } aept_ctl_type;

   // Control of one item in the phase stage
   typedef struct packed {
      logic read_error;
      logic phase_update;
   } aept_s2_ctl_type;

endpackage

// ===== rtl/absolute_encoder_position_tracker_core.sv =====
// Absolute encoder position tracker. Each request beat carries one operation: a
// reading (raw angle, optionally corrected through a 2^TABLE_BITS-entry table and
// mirrored for reverse polarity, then unwrapped into a signed multiturn position
// and a 12-bit motor phase), a table write, a turn-count clear, or a polarity
// change. Every beat yields exactly one response beat. rsp_tvalid rises once the
// beat has passed the table read, tracking and phase stage registers. A new beat
// can be taken every cycle unless a full pipeline is held by rsp_tready low.
// The correction table is one synchronous memory read on the accepting edge; the
// tracking state updates in the stage after it and the phase multiply in the
// stage after that. Table entries hold no value until written and must be written
// before a corrected reading uses them; there is no clearing pass after reset.
// Write configuration only while no beat is in flight.
module absolute_encoder_position_tracker_core #(
   parameter int ANGLE_BITS = 14,
   parameter int TABLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request beat
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_angle[13:0], sample_failed[14], entry_index[24:15],
   // entry_value[38:25], reverse_polarity[39]
   input  logic [aept_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // opcode[1:0]
   input  logic [aept_pkg::OPCODE_W-1:0]        req_tuser,
   // response beat
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // read_error[0], corrected_angle[14:1], uncorrected_angle[28:15],
   // phase_position[40:29], position_count[72:41], zero fill above
   output logic [aept_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // configuration
   input  logic                                 csr_we,
   input  logic [aept_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [aept_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import aept_pkg::*;

   logic               correction_enable_ff;
   logic [PPR_W-1:0]   phase_per_rev_ff;
   logic [PHASE_W-1:0] zero_phase_offset_ff;

   aept_ctl_type          req_ctl;
   logic                  req_fire;
   logic [ANGLE_BITS-1:0] sample_angle;
   logic [TABLE_BITS-1:0] entry_index;
   logic [ANGLE_BITS-1:0] entry_value;

   logic                  s1_valid, s1_fire;
   aept_ctl_type          s1_ctl;
   logic [ANGLE_BITS-1:0] s1_raw, s1_adj, s1_entry;

   logic                  s2_valid, s2_fire, s2_ready;
   aept_s2_ctl_type       s2_ctl;
   logic [ANGLE_BITS-1:0] s2_ang, s2_angle, s2_raw;
   logic [COUNT_W-1:0]    s2_count;

   logic                     out_ready;
   logic                     read_error;
   logic [ANGLE_FIELD_W-1:0] corrected_angle, uncorrected_angle;
   logic [PHASE_W-1:0]       phase_position;
   logic [COUNT_W-1:0]       position_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         correction_enable_ff <= 1'b0;
         phase_per_rev_ff     <= PPR_RESET;
         zero_phase_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CORRECTION_ENABLE: correction_enable_ff <= csr_wdata[0];
            CSR_PHASE_PER_REV:     phase_per_rev_ff     <= csr_wdata;
            CSR_ZERO_PHASE_OFFSET: zero_phase_offset_ff <= csr_wdata[PHASE_W-1:0];
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // Unpack the request beat
   assign req_ctl.op            = req_tuser;
   assign req_ctl.failed        = req_tdata[14];
   assign req_ctl.want_reversed = req_tdata[39];
   assign sample_angle          = ANGLE_BITS'(req_tdata[13:0]);
   assign entry_index           = TABLE_BITS'(req_tdata[24:15]);
   assign entry_value           = ANGLE_BITS'(req_tdata[38:25]);

   // Stage handshakes: each stage moves when the one after it has room
   assign s2_ready   = !s2_valid || out_ready;
   assign s2_fire    = s2_valid && out_ready;
   assign s1_fire    = s1_valid && s2_ready;
   assign req_tready = !s1_valid || s2_ready;
   assign req_fire   = req_tvalid && req_tready;

   aept_table #(
      .ANGLE_BITS (ANGLE_BITS),
      .TABLE_BITS (TABLE_BITS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .req_ctl      (req_ctl),
      .sample_angle (sample_angle),
      .entry_index  (entry_index),
      .entry_value  (entry_value),
      .s1_fire      (s1_fire),
      .s1_valid     (s1_valid),
      .s1_ctl       (s1_ctl),
      .s1_raw       (s1_raw),
      .s1_adj       (s1_adj),
      .s1_entry     (s1_entry)
   );

   aept_track #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_track (
      .clock             (clock),
      .reset             (reset),
      .s1_fire           (s1_fire),
      .s1_ctl            (s1_ctl),
      .s1_raw            (s1_raw),
      .s1_adj            (s1_adj),
      .s1_entry          (s1_entry),
      .correction_enable (correction_enable_ff),
      .s2_fire           (s2_fire),
      .s2_valid          (s2_valid),
      .s2_ctl            (s2_ctl),
      .s2_ang            (s2_ang),
      .s2_angle          (s2_angle),
      .s2_raw            (s2_raw),
      .s2_count          (s2_count)
   );

   aept_phase #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_phase (
      .clock                   (clock),
      .reset                   (reset),
      .s2_valid                (s2_valid),
      .s2_ctl                  (s2_ctl),
      .s2_ang                  (s2_ang),
      .s2_angle                (s2_angle),
      .s2_raw                  (s2_raw),
      .s2_count                (s2_count),
      .phase_positions_per_rev (phase_per_rev_ff),
      .zero_phase_offset       (zero_phase_offset_ff),
      .rsp_tready              (rsp_tready),
      .out_ready               (out_ready),
      .rsp_valid               (rsp_tvalid),
      .read_error              (read_error),
      .corrected_angle         (corrected_angle),
      .uncorrected_angle       (uncorrected_angle),
      .phase_position          (phase_position),
      .position_count          (position_count)
   );

   // Pack the response beat
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, position_count, phase_position,
                       uncorrected_angle, corrected_angle, read_error};

endmodule

// ===== rtl/aept_table.sv =====
module aept_table #(
   parameter int ANGLE_BITS = 14,
   parameter int TABLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_fire,
   input  aept_pkg::aept_ctl_type   req_ctl,
   input  logic [ANGLE_BITS-1:0]    sample_angle,
   input  logic [TABLE_BITS-1:0]    entry_index,
   input  logic [ANGLE_BITS-1:0]    entry_value,
   input  logic                     s1_fire,
   output logic                     s1_valid,
   output aept_pkg::aept_ctl_type   s1_ctl,
   output logic [ANGLE_BITS-1:0]    s1_raw,
   output logic [ANGLE_BITS-1:0]    s1_adj,
   output logic [ANGLE_BITS-1:0]    s1_entry
);
   import aept_pkg::*;

   localparam int DEPTH     = 1 << TABLE_BITS;
   localparam int WIN_SHIFT = (ANGLE_BITS > TABLE_BITS) ? ANGLE_BITS - TABLE_BITS : 0;

   logic [ANGLE_BITS-1:0] table_mem [0:DEPTH-1];

   logic                  s1_valid_ff, s1_valid_in;
   aept_ctl_type          s1_ctl_ff;
   logic [ANGLE_BITS-1:0] s1_raw_ff;
   logic [ANGLE_BITS-1:0] s1_adj_ff;
   logic [ANGLE_BITS-1:0] rd_data_ff;

   logic [TABLE_BITS-1:0] rd_addr;
   logic [ANGLE_BITS-1:0] adj;

   // Pick the window entry or its upper neighbor, and the offset to add to it
   generate
      if (WIN_SHIFT > 0) begin : g_window
         localparam logic [WIN_SHIFT-1:0]  WIN_HALF = WIN_SHIFT'(1) << (WIN_SHIFT - 1);
         localparam logic [ANGLE_BITS-1:0] WIN_SIZE = ANGLE_BITS'(1) << WIN_SHIFT;
         logic [WIN_SHIFT-1:0] off;
         logic                 upper;
         assign off     = sample_angle[WIN_SHIFT-1:0];
         assign upper   = off > WIN_HALF;
         assign rd_addr = sample_angle[ANGLE_BITS-1:WIN_SHIFT] + TABLE_BITS'(upper);
         assign adj     = ANGLE_BITS'(off) - (upper ? WIN_SIZE : '0);
      end else begin : g_direct
         assign rd_addr = TABLE_BITS'(sample_angle);
         assign adj     = '0;
      end
   endgenerate

   // Write a table entry, read the entry for this beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_ctl.op == OP_TABLE_WRITE) begin
            table_mem[entry_index] <= entry_value;
         end
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Stage-one valid: fill on accept, drain when the next stage takes it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the beat payload next to the read data
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff <= req_ctl;
         s1_raw_ff <= sample_angle;
         s1_adj_ff <= adj;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_raw   = s1_raw_ff;
   assign s1_adj   = s1_adj_ff;
   assign s1_entry = rd_data_ff;

endmodule

// ===== rtl/aept_track.sv =====
module aept_track #(
   parameter int ANGLE_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              s1_fire,
   input  aept_pkg::aept_ctl_type            s1_ctl,
   input  logic [ANGLE_BITS-1:0]             s1_raw,
   input  logic [ANGLE_BITS-1:0]             s1_adj,
   input  logic [ANGLE_BITS-1:0]             s1_entry,
   input  logic                              correction_enable,
   input  logic                              s2_fire,
   output logic                              s2_valid,
   output aept_pkg::aept_s2_ctl_type         s2_ctl,
   output logic [ANGLE_BITS-1:0]             s2_ang,
   output logic [ANGLE_BITS-1:0]             s2_angle,
   output logic [ANGLE_BITS-1:0]             s2_raw,
   output logic [aept_pkg::COUNT_W-1:0]      s2_count
);
   import aept_pkg::*;

   localparam int TURN_W = COUNT_W - ANGLE_BITS;
   localparam logic signed [ANGLE_BITS:0] HALF_POS = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);
   localparam logic signed [ANGLE_BITS:0] HALF_NEG = -HALF_POS;

   logic [ANGLE_BITS-1:0] last_angle_ff, last_angle_in;
   logic [ANGLE_BITS-1:0] last_raw_ff, last_raw_in;
   logic [TURN_W-1:0]     turn_ff, turn_in;
   logic                  reversed_ff, reversed_in;

   logic                  s2_valid_ff, s2_valid_in;
   aept_s2_ctl_type       s2_ctl_ff, s2_ctl_in;
   logic [ANGLE_BITS-1:0] s2_ang_ff;
   logic [ANGLE_BITS-1:0] s2_angle_ff;
   logic [ANGLE_BITS-1:0] s2_raw_ff;
   logic [COUNT_W-1:0]    s2_count_ff;

   logic [ANGLE_BITS-1:0]        corr;
   logic [ANGLE_BITS-1:0]        ang_pre;
   logic [ANGLE_BITS-1:0]        ang;
   logic [ANGLE_BITS-1:0]        raw_pol;
   logic signed [ANGLE_BITS:0]   diff;

   // Correct, then mirror for reversed polarity
   assign corr    = s1_entry + s1_adj;
   assign ang_pre = correction_enable ? corr : s1_raw;
   assign ang     = reversed_ff ? ANGLE_BITS'(-ang_pre) : ang_pre;
   assign raw_pol = reversed_ff ? ANGLE_BITS'(-s1_raw) : s1_raw;
   assign diff    = $signed({1'b0, ang}) - $signed({1'b0, last_angle_ff});

   // Apply the operation to the tracking state
   always_comb begin
      last_angle_in = last_angle_ff;
      last_raw_in   = last_raw_ff;
      turn_in       = turn_ff;
      reversed_in   = reversed_ff;
      if (s1_fire) begin
         case (s1_ctl.op)
            OP_READING: begin
               if (!s1_ctl.failed) begin
                  last_raw_in   = raw_pol;
                  last_angle_in = ang;
                  if (diff > HALF_POS) begin
                     turn_in = turn_ff - TURN_W'(1);
                  end else if (diff < HALF_NEG) begin
                     turn_in = turn_ff + TURN_W'(1);
                  end
               end
            end
            OP_CLEAR_TURNS: begin
               turn_in = '0;
            end
            OP_SET_POLARITY: begin
               if (s1_ctl.want_reversed != reversed_ff) begin
                  last_raw_in   = ANGLE_BITS'(-last_raw_ff);
                  last_angle_in = ANGLE_BITS'(-last_angle_ff);
                  reversed_in   = s1_ctl.want_reversed;
               end
            end
            default: begin
               // table writes leave the tracking state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         last_raw_ff   <= '0;
         turn_ff       <= '0;
         reversed_ff   <= 1'b0;
      end else begin
         last_angle_ff <= last_angle_in;
         last_raw_ff   <= last_raw_in;
         turn_ff       <= turn_in;
         reversed_ff   <= reversed_in;
      end
   end

   // Stage-two valid and control
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_fire) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
      s2_ctl_in.read_error   = (s1_ctl.op == OP_READING) && s1_ctl.failed;
      s2_ctl_in.phase_update = (s1_ctl.op == OP_READING) && !s1_ctl.failed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_ctl_ff   <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (s1_fire) begin
            s2_ctl_ff <= s2_ctl_in;
         end
      end
   end

   // Snapshot the state after this beat
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_ang_ff   <= ang;
         s2_angle_ff <= last_angle_in;
         s2_raw_ff   <= last_raw_in;
         s2_count_ff <= {turn_in, last_angle_in};
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_ctl   = s2_ctl_ff;
   assign s2_ang   = s2_ang_ff;
   assign s2_angle = s2_angle_ff;
   assign s2_raw   = s2_raw_ff;
   assign s2_count = s2_count_ff;

endmodule

// ===== rtl/aept_phase.sv =====
module aept_phase #(
   parameter int ANGLE_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 s2_valid,
   input  aept_pkg::aept_s2_ctl_type            s2_ctl,
   input  logic [ANGLE_BITS-1:0]                s2_ang,
   input  logic [ANGLE_BITS-1:0]                s2_angle,
   input  logic [ANGLE_BITS-1:0]                s2_raw,
   input  logic [aept_pkg::COUNT_W-1:0]         s2_count,
   input  logic [aept_pkg::PPR_W-1:0]           phase_positions_per_rev,
   input  logic [aept_pkg::PHASE_W-1:0]         zero_phase_offset,
   input  logic                                 rsp_tready,
   output logic                                 out_ready,
   output logic                                 rsp_valid,
   output logic                                 read_error,
   output logic [aept_pkg::ANGLE_FIELD_W-1:0]   corrected_angle,
   output logic [aept_pkg::ANGLE_FIELD_W-1:0]   uncorrected_angle,
   output logic [aept_pkg::PHASE_W-1:0]         phase_position,
   output logic [aept_pkg::COUNT_W-1:0]         position_count
);
   import aept_pkg::*;

   localparam int PROD_W = ANGLE_BITS + PPR_W;

   logic [PHASE_W-1:0]       last_phase_ff, last_phase_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_err_ff;
   logic [ANGLE_FIELD_W-1:0] out_corr_ff;
   logic [ANGLE_FIELD_W-1:0] out_raw_ff;
   logic [PHASE_W-1:0]       out_phase_ff;
   logic [COUNT_W-1:0]       out_count_ff;

   logic [PROD_W-1:0]  prod;
   logic [PHASE_W-1:0] phase_new;
   logic               s2_fire;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s2_fire   = s2_valid && out_ready;

   // Scale the angle to phase positions and add the zero offset
   assign prod      = PROD_W'(s2_ang) * PROD_W'(phase_positions_per_rev);
   assign phase_new = prod[ANGLE_BITS +: PHASE_W] + zero_phase_offset;

   always_comb begin
      last_phase_in = last_phase_ff;
      if (s2_fire && s2_ctl.phase_update) begin
         last_phase_in = phase_new;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s2_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         last_phase_ff <= last_phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (s2_fire) begin
         out_err_ff   <= s2_ctl.read_error;
         out_corr_ff  <= ANGLE_FIELD_W'(s2_angle);
         out_raw_ff   <= ANGLE_FIELD_W'(s2_raw);
         out_phase_ff <= last_phase_in;
         out_count_ff <= s2_count;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign read_error        = out_err_ff;
   assign corrected_angle   = out_corr_ff;
   assign uncorrected_angle = out_raw_ff;
   assign phase_position    = out_phase_ff;
   assign position_count    = out_count_ff;

endmodule
